// ----- rtl/core/i2cm_pkg.sv -----
// Shared types, codes and delay table for the I2C master bit engine.
package i2cm_pkg;

    localparam int TickW = 12;
    localparam int UsW   = 5;

    localparam logic [TickW-1:0] TicksPerUsReset = 12'd480;

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4,
        KIND_WACK  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ST_A       = 4'd1,
        PH_ST_B       = 4'd2,
        PH_SP_A       = 4'd3,
        PH_SP_B       = 4'd4,
        PH_WA         = 4'd5,
        PH_WR_A       = 4'd6,
        PH_WR_DATA    = 4'd7,
        PH_WR_HIGH    = 4'd8,
        PH_WR_LOW     = 4'd9,
        PH_WR_TAIL    = 4'd10,
        PH_RD_LOW     = 4'd11,
        PH_RD_HIGH    = 4'd12,
        PH_RD_ACKSET  = 4'd13,
        PH_RD_ACKHIGH = 4'd14
    } phase_t;

    // Delay of each phase in microseconds
    function automatic logic [UsW-1:0] phase_wait_us(input phase_t ph);
        logic [UsW-1:0] w;
        case (ph)
            PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_HIGH: w = 5'd4;
            PH_WA:                                         w = 5'd20;
            PH_IDLE:                                       w = 5'd0;
            default:                                       w = 5'd2;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/i2c_master_bit_engine.sv -----
// I2C master bit engine: tick-driven bus sequencer with registered result stream.
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid / s_tready     | s_tuser kind, s_tdata tick fields
//  m_      | out | m_tvalid / m_tready     | m_tdata pin levels and status
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data ticks_per_us
//
// Each accepted tick updates the sequencer and loads the result
// register; one result per tick, a new tick every cycle while results drain.
// s_tready drops only while a result waits and m_tready is low.
// aresetn is synchronous, active low; the bus idles with SCL and SDA high.
// cfg_ready is always high.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [2:0] kind
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_in, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] sda_drive,
                                   // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                   // [13] nack_seen, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    logic [TickW-1:0] tpu_cfg_reg;

    phase_t           phase_reg, phase_next;
    logic [TickW-1:0] tick_reg, tick_next;
    logic [UsW-1:0]   us_reg, us_next;
    logic [3:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       rx_reg, rx_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             dir_reg, dir_next;
    logic             nack_reg, nack_next;
    logic             ackc_reg, ackc_next;
    logic             done;

    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;

    logic             accept;
    logic [TickW-1:0] tpu;
    logic [TickW-1:0] tick_inc;
    logic [UsW-1:0]   us_inc;
    logic [3:0]       bit_inc;

    kind_t            kind;
    logic [7:0]       tx_byte;
    logic             send_ack;
    logic             sda_in;

    assign kind     = kind_t'(s_tuser);
    assign tx_byte  = s_tdata[7:0];
    assign send_ack = s_tdata[8];
    assign sda_in   = s_tdata[9];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign tpu      = (tpu_cfg_reg == '0) ? TickW'(1) : tpu_cfg_reg;
    assign tick_inc = tick_reg + TickW'(1);
    assign us_inc   = us_reg + UsW'(1);
    assign bit_inc  = bit_reg + 4'd1;

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        us_next    = us_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        dir_next   = dir_reg;
        nack_next  = nack_reg;
        ackc_next  = ackc_reg;
        done       = 1'b0;

        if (phase_reg == PH_IDLE) begin
            case (kind)
                KIND_START: begin
                    dir_next = 1'b1; scl_next = 1'b1; sda_next = 1'b1;
                    phase_next = PH_ST_A; tick_next = '0; us_next = '0;
                end
                KIND_STOP: begin
                    dir_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                    phase_next = PH_SP_A; tick_next = '0; us_next = '0;
                end
                KIND_WRITE: begin
                    dir_next = 1'b1; scl_next = 1'b0; shift_next = tx_byte;
                    bit_next = '0;
                    phase_next = PH_WR_A; tick_next = '0; us_next = '0;
                end
                KIND_READ: begin
                    dir_next = 1'b0; scl_next = 1'b0; shift_next = '0;
                    bit_next = '0; ackc_next = send_ack;
                    phase_next = PH_RD_LOW; tick_next = '0; us_next = '0;
                end
                KIND_WACK: begin
                    // release SDA in the same update that raises SCL
                    dir_next = 1'b0; sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = PH_WA; tick_next = '0; us_next = '0;
                end
                default: ;
            endcase
        end else if (tick_inc >= tpu) begin
            tick_next = '0;
            us_next   = us_inc;
            if (us_inc >= phase_wait_us(phase_reg)) begin
                us_next = '0;
                case (phase_reg)
                    PH_ST_A: begin
                        sda_next = 1'b0; phase_next = PH_ST_B;
                    end
                    PH_ST_B: begin
                        scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                    end
                    PH_SP_A: begin
                        scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_SP_B;
                    end
                    PH_WA: begin
                        nack_next = sda_in; scl_next = 1'b0;
                        phase_next = PH_IDLE; done = 1'b1;
                    end
                    PH_WR_A: begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_WR_DATA;
                    end
                    PH_WR_DATA: begin
                        scl_next = 1'b1; phase_next = PH_WR_HIGH;
                    end
                    PH_WR_HIGH: begin
                        scl_next = 1'b0; phase_next = PH_WR_LOW;
                    end
                    PH_WR_LOW: begin
                        bit_next = bit_inc;
                        if (bit_inc < 4'd8) begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = PH_WR_DATA;
                        end else begin
                            phase_next = PH_WR_TAIL;
                        end
                    end
                    PH_RD_LOW: begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[6:0], sda_in};
                        phase_next = PH_RD_HIGH;
                    end
                    PH_RD_HIGH: begin
                        bit_next = bit_inc;
                        scl_next = 1'b0;
                        if (bit_inc < 4'd8) begin
                            phase_next = PH_RD_LOW;
                        end else begin
                            rx_next    = shift_reg;
                            dir_next   = 1'b1;
                            sda_next   = !ackc_reg;
                            phase_next = PH_RD_ACKSET;
                        end
                    end
                    PH_RD_ACKSET: begin
                        scl_next = 1'b1; phase_next = PH_RD_ACKHIGH;
                    end
                    PH_RD_ACKHIGH: begin
                        scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                    end
                    default: begin
                        // stop tail and write tail just finish
                        phase_next = PH_IDLE; done = 1'b1;
                    end
                endcase
            end
        end else begin
            tick_next = tick_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_cfg_reg <= TicksPerUsReset;
        end else if (cfg_valid) begin
            tpu_cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            us_reg    <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            rx_reg    <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            dir_reg   <= 1'b1;
            nack_reg  <= 1'b0;
            ackc_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            us_reg    <= us_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            dir_reg   <= dir_next;
            nack_reg  <= nack_next;
            ackc_reg  <= ackc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {2'b00, nack_next, rx_next, done,
                            (phase_next != PH_IDLE), dir_next, sda_next, scl_next};
        end
    end

endmodule
